[rtl/core/pgmog_pkg.sv]
// ----------------------------------------------------------------------------
// pgmog_pkg
// Types and constants shared by the PGM to occupancy grid converter and its
// port checker.
// ----------------------------------------------------------------------------
package pgmog_pkg;

  // Default size limits
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int ACC_W = 17;   // decimal accumulator, saturates at ACC_SAT
  localparam int THR_W = 17;   // Q1.16 thresholds
  localparam int LIM_W = 33;   // threshold scaled by maxval
  localparam int MAXV_W = 16;
  localparam int IDX_W = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [ACC_W-1:0] ACC_SAT    = 17'd65536;
  localparam logic [ACC_W-1:0] SAMPLE_MAX = 17'd65535;

  localparam logic [THR_W-1:0] OCC_THR_RST  = 17'd42598;  // 0.65
  localparam logic [THR_W-1:0] FREE_THR_RST = 17'd16384;  // 0.25

  localparam logic signed [7:0] CELL_OCC     = 8'sd100;
  localparam logic signed [7:0] CELL_FREE    = 8'sd0;
  localparam logic signed [7:0] CELL_UNKNOWN = -8'sd1;

  // Characters of the file format
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_HASH  = 8'd35;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_TWO   = 8'd50;
  localparam logic [7:0] CH_FIVE  = 8'd53;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_P     = 8'd80;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_MAGIC  = 3'd1,
    ERR_HEADER = 3'd2,
    ERR_SIZE   = 3'd3,
    ERR_SHORT  = 3'd4
  } err_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEGATE   = 2'd0,
    CFG_OCC_THR  = 2'd1,
    CFG_FREE_THR = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] cell_value;
    logic [IDX_W-1:0]  cell_index;
    logic [2:0]        error_code;
    logic              last;
  } out_item_t;

endpackage

[rtl/core/pgm_to_occupancy_grid.sv]
// ----------------------------------------------------------------------------
// pgm_to_occupancy_grid
// Parses a PGM (P5/P2) byte stream and emits one occupancy cell per pixel,
// with a row-flipped grid index, or an error result.
// ----------------------------------------------------------------------------
// A result is registered in the queue when its byte is taken. Throughput:
//   one byte per cycle while in_stall is low; each byte is handled by one pass
//   through the parser logic into a four-entry result queue. A byte yields up
//   to two results; in_stall rises while fewer than two queue slots are free.
// Reset: synchronous, active low; parser returns to expecting the magic,
//   queue empties, configuration returns to its defaults.
module pgm_to_occupancy_grid #(
  parameter int MAX_WIDTH  = pgmog_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pgmog_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pgmog_pkg::in_item_t            in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pgmog_pkg::out_item_t           out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pgmog_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pgmog_pkg::THR_W-1:0]    cfg_data
);
  import pgmog_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);  // cell count
  localparam int CLW  = $clog2(MAX_WIDTH + 1);               // column
  localparam int IXW  = (CW > IDX_W) ? CW : IDX_W;
  localparam int QD   = 4;
  localparam int QPW  = $clog2(QD);
  localparam int QCW  = $clog2(QD + 1);

  typedef enum logic [12:0] {
    PH_MAG_SKIP  = 13'b0000000000001,
    PH_MAG_P     = 13'b0000000000010,
    PH_MAG_END   = 13'b0000000000100,
    PH_W_SKIP    = 13'b0000000001000,
    PH_W_NUM     = 13'b0000000010000,
    PH_H_SKIP    = 13'b0000000100000,
    PH_H_NUM     = 13'b0000001000000,
    PH_M_SKIP    = 13'b0000010000000,
    PH_M_NUM     = 13'b0000100000000,
    PH_DATA_SKIP = 13'b0001000000000,
    PH_DATA_NUM  = 13'b0010000000000,
    PH_DONE      = 13'b0100000000000,
    PH_ERROR     = 13'b1000000000000
  } phase_t;

  // Configuration
  logic             negate_r;
  logic [THR_W-1:0] occ_thr_r;
  logic [THR_W-1:0] free_thr_r;

  // Parser state
  phase_t            ph_r, ph_nxt;
  logic              cmt_r, cmt_nxt;
  logic              asc_r, asc_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [ACC_W-1:0]  wid_r, wid_nxt;
  logic [ACC_W-1:0]  hgt_r, hgt_nxt;
  logic [MAXV_W-1:0] max_r, max_nxt;
  logic [CW-1:0]     cells_r, cells_nxt;   // W*H during header, then remaining
  logic [CW-1:0]     rb_r, rb_nxt;
  logic [CLW-1:0]    col_r, col_nxt;
  logic [LIM_W-1:0]  occ_lim_r, occ_lim_nxt;
  logic [LIM_W-1:0]  free_lim_r, free_lim_nxt;

  // Result queue
  out_item_t        q_r [QD];
  logic [QPW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]   cnt_r;

  logic in_fire, out_fire;
  logic [7:0] b;
  logic [3:0] digit;
  logic is_digit, is_space;

  assign in_fire  = in_valid & ~in_stall;
  assign out_fire = out_valid & ~out_stall;
  assign b        = in_data.data_byte;
  assign digit    = b[3:0];
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));

  // Decimal accumulation, and width * height built digit by digit alongside
  logic [20:0]       acc_x10;
  logic [ACC_W-1:0]  acc_step;
  logic [20:0]       dw;
  logic [CW-1:0]     cells_step;
  logic [LIM_W-1:0]  occ_prod, free_prod;
  logic              size_bad;

  assign acc_x10    = 21'({acc_r, 3'b000}) + 21'({acc_r, 1'b0}) + 21'(digit);
  assign acc_step   = (acc_x10 > 21'(ACC_SAT)) ? ACC_SAT : acc_x10[ACC_W-1:0];
  assign dw         = 21'(digit) * 21'(wid_r);
  assign cells_step = CW'({cells_r, 3'b000}) + CW'({cells_r, 1'b0}) + CW'(dw);

  // thresholds scaled by maxval when the header ends (17 x 16 bits)
  assign occ_prod   = LIM_W'(occ_thr_r) * LIM_W'(acc_r[MAXV_W-1:0]);
  assign free_prod  = LIM_W'(free_thr_r) * LIM_W'(acc_r[MAXV_W-1:0]);

  assign size_bad = (wid_r == '0) || (wid_r > ACC_W'(MAX_WIDTH))
                 || (hgt_r == '0) || (hgt_r > ACC_W'(MAX_HEIGHT))
                 || (acc_r == '0) || (acc_r > SAMPLE_MAX);

  // Cell classification
  logic [ACC_W-1:0]  pix;
  logic signed [17:0] frac;
  logic              is_occ, is_free;
  logic [IXW-1:0]    idx_wide;
  logic [CW-1:0]     rem_dec;
  logic [CLW-1:0]    col_inc;
  out_item_t         cell_res;

  assign pix  = (ph_r == PH_DATA_NUM) ? acc_r : ACC_W'(b);
  assign frac = negate_r ? $signed({1'b0, pix})
                         : $signed({2'b00, max_r} - {1'b0, pix});
  assign is_occ  = $signed({frac, 16'h0000}) > $signed({1'b0, occ_lim_r});
  assign is_free = $signed({frac, 16'h0000}) < $signed({1'b0, free_lim_r});
  assign idx_wide = IXW'(rb_r) + IXW'(col_r);
  assign rem_dec  = cells_r - CW'(1);
  assign col_inc  = col_r + CLW'(1);

  always_comb begin
    cell_res.cell_value = is_occ ? CELL_OCC : (is_free ? CELL_FREE : CELL_UNKNOWN);
    cell_res.cell_index = idx_wide[IDX_W-1:0];
    cell_res.error_code = ERR_NONE;
    cell_res.last       = (rem_dec == '0);
  end

  // Per-byte parse
  logic       emit, tail_chk, fail_now;
  err_code_t  fail_code;
  logic [1:0] n_res;
  out_item_t  res0, res1;

  always_comb begin
    ph_nxt       = ph_r;
    cmt_nxt      = cmt_r;
    asc_nxt      = asc_r;
    acc_nxt      = acc_r;
    wid_nxt      = wid_r;
    hgt_nxt      = hgt_r;
    max_nxt      = max_r;
    cells_nxt    = cells_r;
    rb_nxt       = rb_r;
    col_nxt      = col_r;
    occ_lim_nxt  = occ_lim_r;
    free_lim_nxt = free_lim_r;
    emit         = 1'b0;
    tail_chk     = 1'b0;
    fail_now     = 1'b0;
    fail_code    = ERR_NONE;
    n_res        = 2'd0;
    res0         = '0;
    res1         = '0;

    // Other fields are always loaded before they are read, so a restart
    // only needs the phase and the comment flag.
    if (in_data.start_of_file) begin
      ph_nxt  = PH_MAG_SKIP;
      cmt_nxt = 1'b0;
    end

    if (in_data.end_of_file) begin
      case (ph_nxt)
        PH_MAG_SKIP, PH_MAG_P: begin
          fail_now  = 1'b1;
          fail_code = ERR_MAGIC;
        end
        PH_MAG_END, PH_W_SKIP, PH_W_NUM, PH_H_SKIP, PH_H_NUM, PH_M_SKIP: begin
          fail_now  = 1'b1;
          fail_code = ERR_HEADER;
        end
        PH_M_NUM: begin
          fail_now  = 1'b1;
          fail_code = size_bad ? ERR_SIZE : ERR_SHORT;
        end
        PH_DATA_SKIP: begin
          fail_now  = 1'b1;
          fail_code = ERR_SHORT;
        end
        PH_DATA_NUM: begin
          if (acc_r > SAMPLE_MAX) begin
            fail_now  = 1'b1;
            fail_code = ERR_SHORT;
          end else begin
            ph_nxt   = PH_DATA_SKIP;
            emit     = 1'b1;
            tail_chk = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      case (ph_nxt)
        PH_MAG_SKIP: begin
          if (cmt_nxt) begin
            if (b == CH_LF) cmt_nxt = 1'b0;
          end else if (b == CH_HASH) begin
            cmt_nxt = 1'b1;
          end else if (!is_space) begin
            if (b == CH_P) begin
              ph_nxt = PH_MAG_P;
            end else begin
              fail_now  = 1'b1;
              fail_code = ERR_MAGIC;
            end
          end
        end
        PH_MAG_P: begin
          if (b == CH_FIVE) begin
            asc_nxt = 1'b0;
            ph_nxt  = PH_MAG_END;
          end else if (b == CH_TWO) begin
            asc_nxt = 1'b1;
            ph_nxt  = PH_MAG_END;
          end else begin
            fail_now  = 1'b1;
            fail_code = ERR_MAGIC;
          end
        end
        PH_MAG_END: begin
          if (is_space) begin
            ph_nxt = PH_W_SKIP;
          end else begin
            fail_now  = 1'b1;
            fail_code = ERR_MAGIC;
          end
        end
        PH_W_SKIP, PH_H_SKIP, PH_M_SKIP: begin
          if (cmt_r) begin
            if (b == CH_LF) cmt_nxt = 1'b0;
          end else if (b == CH_HASH) begin
            cmt_nxt = 1'b1;
          end else if (!is_space) begin
            if (is_digit) begin
              acc_nxt = ACC_W'(digit);
              if (ph_r == PH_W_SKIP) begin
                ph_nxt = PH_W_NUM;
              end else if (ph_r == PH_H_SKIP) begin
                ph_nxt    = PH_H_NUM;
                cells_nxt = CW'(dw);
              end else begin
                ph_nxt = PH_M_NUM;
              end
            end else begin
              fail_now  = 1'b1;
              fail_code = ERR_HEADER;
            end
          end
        end
        PH_W_NUM, PH_H_NUM, PH_M_NUM: begin
          if (is_digit) begin
            acc_nxt = acc_step;
            if (ph_r == PH_H_NUM) cells_nxt = cells_step;
          end else if (!is_space) begin
            fail_now  = 1'b1;
            fail_code = ERR_HEADER;
          end else if (ph_r == PH_W_NUM) begin
            wid_nxt = acc_r;
            ph_nxt  = PH_H_SKIP;
          end else if (ph_r == PH_H_NUM) begin
            hgt_nxt = acc_r;
            ph_nxt  = PH_M_SKIP;
          end else if (size_bad) begin
            fail_now  = 1'b1;
            fail_code = ERR_SIZE;
          end else begin
            // header complete: cells_r already holds width * height
            max_nxt      = acc_r[MAXV_W-1:0];
            occ_lim_nxt  = occ_prod;
            free_lim_nxt = free_prod;
            col_nxt      = '0;
            rb_nxt       = cells_r - CW'(wid_r);
            ph_nxt       = PH_DATA_SKIP;
          end
        end
        PH_DATA_SKIP: begin
          if (!asc_r) begin
            emit = 1'b1;
          end else if (is_digit) begin
            acc_nxt = ACC_W'(digit);
            ph_nxt  = PH_DATA_NUM;
          end else if (!is_space) begin
            fail_now  = 1'b1;
            fail_code = ERR_SHORT;
          end
        end
        PH_DATA_NUM: begin
          if (is_digit) begin
            acc_nxt = acc_step;
          end else if (!is_space || (acc_r > SAMPLE_MAX)) begin
            fail_now  = 1'b1;
            fail_code = ERR_SHORT;
          end else begin
            ph_nxt = PH_DATA_SKIP;
            emit   = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (fail_now) begin
      res0.error_code = fail_code;
      res0.last       = 1'b1;
      n_res           = 2'd1;
      ph_nxt          = PH_ERROR;
      cmt_nxt         = 1'b0;
    end else if (emit) begin
      res0      = cell_res;
      n_res     = 2'd1;
      cells_nxt = rem_dec;
      if (ACC_W'(col_inc) >= wid_r) begin
        col_nxt = '0;
        rb_nxt  = rb_r - CW'(wid_r);
      end else begin
        col_nxt = col_inc;
      end
      if (rem_dec == '0) begin
        ph_nxt = PH_DONE;
      end else if (tail_chk) begin
        // file ended on the value but cells are still owed
        res1.error_code = ERR_SHORT;
        res1.last       = 1'b1;
        n_res           = 2'd2;
        ph_nxt          = PH_ERROR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_MAG_SKIP;
      cmt_r <= 1'b0;
    end else if (in_fire) begin
      ph_r  <= ph_nxt;
      cmt_r <= cmt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      asc_r      <= asc_nxt;
      acc_r      <= acc_nxt;
      wid_r      <= wid_nxt;
      hgt_r      <= hgt_nxt;
      max_r      <= max_nxt;
      cells_r    <= cells_nxt;
      rb_r       <= rb_nxt;
      col_r      <= col_nxt;
      occ_lim_r  <= occ_lim_nxt;
      free_lim_r <= free_lim_nxt;
    end
  end

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      negate_r   <= 1'b0;
      occ_thr_r  <= OCC_THR_RST;
      free_thr_r <= FREE_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NEGATE:   negate_r   <= cfg_data[0];
        CFG_OCC_THR:  occ_thr_r  <= cfg_data;
        CFG_FREE_THR: free_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result queue
  logic [1:0]     push_n;
  logic [QPW-1:0] wr_ptr_p1;

  assign push_n    = in_fire ? n_res : 2'd0;
  assign wr_ptr_p1 = wr_ptr_r + QPW'(1);

  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) begin
      if ((push_n != 2'd0) && (QPW'(i) == wr_ptr_r)) begin
        q_r[i] <= res0;
      end else if ((push_n == 2'd2) && (QPW'(i) == wr_ptr_p1)) begin
        q_r[i] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPW'(push_n);
      rd_ptr_r <= rd_ptr_r + QPW'(out_fire);
      cnt_r    <= cnt_r + QCW'(push_n) - QCW'(out_fire);
    end
  end

  assign in_stall  = (cnt_r > QCW'(QD - 2));
  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_ptr_r];

endmodule

[rtl/core/pgmog_checker.sv]
// ----------------------------------------------------------------------------
// pgmog_checker
// Port-level checks for the PGM to occupancy grid converter.
// ----------------------------------------------------------------------------
module pgmog_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input pgmog_pkg::in_item_t             in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input pgmog_pkg::out_item_t            out_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [pgmog_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [pgmog_pkg::THR_W-1:0]     cfg_data
);
  import pgmog_pkg::*;

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an error transaction closes the file and carries no cell
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.error_code != ERR_NONE)) |->
      (out_data.last && (out_data.cell_value == CELL_FREE)
       && (out_data.cell_index == '0)))
    else $error("error result with cell payload or without last");

  a_cell_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.cell_value == CELL_OCC)
                || (out_data.cell_value == CELL_FREE)
                || (out_data.cell_value == CELL_UNKNOWN)))
    else $error("cell value outside occupied/free/unknown");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind pgm_to_occupancy_grid pgmog_checker u_pgmog_checker (.*);

[test/pgm_to_occupancy_grid_test.sv]
// ----------------------------------------------------------------------------
// pgm_to_occupancy_grid_test
// Drives PGM files (raw and ASCII, clean and broken) into the grid converter
// and checks every cell and error result against a cycle-free model of the
// parser, across several threshold settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module pgm_to_occupancy_grid_test;
  import pgmog_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  typedef enum logic [3:0] {
    MAGIC_WS, MAGIC_P, MAGIC_SEP,
    WIDTH_WS, WIDTH_DIG, HEIGHT_WS, HEIGHT_DIG, MAXV_WS, MAXV_DIG,
    PIX_WS, PIX_DIG, FILE_DONE, FILE_ERR
  } parse_step_t;

  // Tracks the parser state, predicts cells and compares the ones that come out.
  class cell_checker;
    bit               negate;
    logic [THR_W-1:0] occ_thr;
    logic [THR_W-1:0] free_thr;
    parse_step_t      phase;
    bit               in_comment;
    bit               ascii;
    int unsigned      acc, width, height, maxval;
    int unsigned      column, row_base, cells_left;
    longint           occ_limit, free_limit;
    out_item_t        cells_due[$];
    int               errors;

    function new();
      negate   = 1'b0;
      occ_thr  = OCC_THR_RST;
      free_thr = FREE_THR_RST;
      errors   = 0;
      restart();
    endfunction

    function void restart();
      phase      = MAGIC_WS;
      in_comment = 1'b0;
      ascii      = 1'b0;
      acc        = 0;
      width      = 0;
      height     = 0;
      maxval     = 0;
      column     = 0;
      row_base   = 0;
      cells_left = 0;
      occ_limit  = 0;
      free_limit = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [THR_W-1:0] val);
      case (idx)
        CFG_NEGATE:   negate = val[0];
        CFG_OCC_THR:  occ_thr = val;
        CFG_FREE_THR: free_thr = val;
        default: ;
      endcase
    endfunction

    function bit is_space(logic [7:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function void add_digit(logic [7:0] b);
      acc = acc * 10 + (b - CH_ZERO);
      if (acc > ACC_SAT) acc = ACC_SAT;
    endfunction

    function void push(logic signed [7:0] val, int unsigned idx, err_code_t code, bit last);
      out_item_t e;
      e.cell_value = val;
      e.cell_index = idx[IDX_W-1:0];
      e.error_code = code;
      e.last       = last;
      cells_due.insert(cells_due.size(), e);
    endfunction

    function void fail(err_code_t code);
      push(CELL_FREE, 0, code, 1'b1);
      phase      = FILE_ERR;
      in_comment = 1'b0;
    endfunction

    function void emit(longint pix);
      longint            frac;
      logic signed [7:0] val;
      frac = negate ? pix : longint'(maxval) - pix;
      frac = frac * 65536;
      if (frac > occ_limit) val = CELL_OCC;
      else if (frac < free_limit) val = CELL_FREE;
      else val = CELL_UNKNOWN;
      cells_left--;
      push(val, row_base + column, ERR_NONE, cells_left == 0);
      column++;
      if (column >= width) begin
        column = 0;
        row_base -= width;
      end
      if (cells_left == 0) phase = FILE_DONE;
    endfunction

    function err_code_t finish_header();
      maxval = acc;
      if (width == 0 || width > MAX_WIDTH_DEF || height == 0 || height > MAX_HEIGHT_DEF ||
          maxval == 0 || maxval > SAMPLE_MAX)
        return ERR_SIZE;
      occ_limit  = longint'(occ_thr) * longint'(maxval);
      free_limit = longint'(free_thr) * longint'(maxval);
      column     = 0;
      row_base   = (height - 1) * width;
      cells_left = width * height;
      return ERR_NONE;
    endfunction

    function void skip_to(logic [7:0] b, parse_step_t next);
      if (in_comment) begin
        if (b == CH_LF) in_comment = 1'b0;
      end else if (b == CH_HASH) begin
        in_comment = 1'b1;
      end else if (!is_space(b)) begin
        if (is_digit(b)) begin
          acc   = b - CH_ZERO;
          phase = next;
        end else begin
          fail(ERR_HEADER);
        end
      end
    endfunction

    function void parse_byte(logic [7:0] b);
      err_code_t code;
      case (phase)
        MAGIC_WS: begin
          if (in_comment) begin
            if (b == CH_LF) in_comment = 1'b0;
          end else if (b == CH_HASH) begin
            in_comment = 1'b1;
          end else if (!is_space(b)) begin
            if (b == CH_P) phase = MAGIC_P;
            else fail(ERR_MAGIC);
          end
        end
        MAGIC_P: begin
          if (b == CH_FIVE) begin
            ascii = 1'b0;
            phase = MAGIC_SEP;
          end else if (b == CH_TWO) begin
            ascii = 1'b1;
            phase = MAGIC_SEP;
          end else begin
            fail(ERR_MAGIC);
          end
        end
        MAGIC_SEP: begin
          if (is_space(b)) phase = WIDTH_WS;
          else fail(ERR_MAGIC);
        end
        WIDTH_WS:  skip_to(b, WIDTH_DIG);
        HEIGHT_WS: skip_to(b, HEIGHT_DIG);
        MAXV_WS:   skip_to(b, MAXV_DIG);
        WIDTH_DIG, HEIGHT_DIG, MAXV_DIG: begin
          if (is_digit(b)) begin
            add_digit(b);
          end else if (!is_space(b)) begin
            fail(ERR_HEADER);
          end else if (phase == WIDTH_DIG) begin
            width = acc;
            phase = HEIGHT_WS;
          end else if (phase == HEIGHT_DIG) begin
            height = acc;
            phase  = MAXV_WS;
          end else begin
            code = finish_header();
            if (code != ERR_NONE) fail(code);
            else phase = PIX_WS;
          end
        end
        PIX_WS: begin
          if (!ascii) begin
            emit(longint'(b));
          end else if (is_digit(b)) begin
            acc   = b - CH_ZERO;
            phase = PIX_DIG;
          end else if (!is_space(b)) begin
            fail(ERR_SHORT);
          end
        end
        PIX_DIG: begin
          if (is_digit(b)) begin
            add_digit(b);
          end else if (!is_space(b) || acc > SAMPLE_MAX) begin
            fail(ERR_SHORT);
          end else begin
            phase = PIX_WS;
            emit(longint'(acc));
          end
        end
        default: ;
      endcase
    endfunction

    function void parse_end();
      err_code_t code;
      case (phase)
        MAGIC_WS, MAGIC_P: fail(ERR_MAGIC);
        MAGIC_SEP, WIDTH_WS, WIDTH_DIG, HEIGHT_WS, HEIGHT_DIG, MAXV_WS: fail(ERR_HEADER);
        MAXV_DIG: begin
          code = finish_header();
          fail(code != ERR_NONE ? code : ERR_SHORT);
        end
        PIX_WS: fail(ERR_SHORT);
        PIX_DIG: begin
          if (acc > SAMPLE_MAX) begin
            fail(ERR_SHORT);
          end else begin
            // a value cut off by the end of file still counts
            phase = PIX_WS;
            emit(longint'(acc));
            if (cells_left != 0) fail(ERR_SHORT);
          end
        end
        default: ;
      endcase
    endfunction

    // Returns 1 when the transaction can change the parser at all.
    function bit note_byte(in_item_t it);
      bit live;
      live = it.start_of_file || (phase != FILE_DONE && phase != FILE_ERR);
      if (it.start_of_file) restart();
      if (it.end_of_file) parse_end();
      else parse_byte(it.data_byte);
      return live;
    endfunction

    function void check_cell(out_item_t got);
      out_item_t want;
      if (cells_due.size() == 0) begin
        $error("unexpected result: value %0d index %0d code %0d last %0b",
               got.cell_value, got.cell_index, got.error_code, got.last);
        errors++;
        return;
      end
      want = cells_due.pop_front();
      if (got.cell_value !== want.cell_value) begin
        $error("cell_value: expected %0d, got %0d", want.cell_value, got.cell_value);
        errors++;
      end
      if (got.cell_index !== want.cell_index) begin
        $error("cell_index: expected %0d, got %0d", want.cell_index, got.cell_index);
        errors++;
      end
      if (got.error_code !== want.error_code) begin
        $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [THR_W-1:0]     cfg_data;

  cell_checker sb;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          live_items;

  pgm_to_occupancy_grid i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_cell(out_data);
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---- file builders ----

  function automatic void put_byte(ref byte_q_t f, input logic [7:0] c);
    f.insert(f.size(), c);
  endfunction

  function automatic void add_text(ref byte_q_t f, input string s);
    for (int i = 0; i < s.len(); i++) put_byte(f, s[i]);
  endfunction

  function automatic void add_ws(ref byte_q_t f, input int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 5);
      put_byte(f, (r == 5) ? CH_SPACE : 8'(CH_TAB + r));
    end
  endfunction

  // optional extra whitespace and a comment with arbitrary bytes
  function automatic void add_gap(ref byte_q_t f);
    logic [7:0] c;
    if ($urandom_range(0, 1)) add_ws(f, $urandom_range(1, 2));
    if ($urandom_range(0, 4) == 0) begin
      put_byte(f, CH_HASH);
      repeat ($urandom_range(0, 6)) begin
        c = 8'($urandom_range(0, 255));
        put_byte(f, (c == CH_LF) ? CH_SPACE : c);
      end
      put_byte(f, CH_LF);
    end
  endfunction

  function automatic void add_num(ref byte_q_t f, input int unsigned n);
    if ($urandom_range(0, 9) == 0) put_byte(f, CH_ZERO);
    add_text(f, $sformatf("%0d", n));
  endfunction

  function automatic void make_file(ref byte_q_t f, output bit closed, output bit marked);
    int unsigned w, h, mv, cells, npix, pix, cut;
    int          kind;
    bit          ascii;
    f.delete();
    closed = ($urandom_range(0, 19) != 0);
    marked = ($urandom_range(0, 29) != 0);
    kind   = $urandom_range(0, 99);
    if (kind < 4) begin
      repeat ($urandom_range(1, 12)) put_byte(f, 8'($urandom_range(0, 255)));
      return;
    end
    ascii = 1'($urandom_range(0, 1));
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 6);
    case ($urandom_range(0, 3))
      0: mv = 255;
      1: mv = $urandom_range(1, 15);
      2: mv = $urandom_range(1, 65535);
      default: mv = 65535;
    endcase
    if (kind >= 92) begin
      case ($urandom_range(0, 5))
        0: w = 0;
        1: h = 0;
        2: w = $urandom_range(MAX_WIDTH_DEF + 1, 9999);
        3: h = $urandom_range(MAX_HEIGHT_DEF + 1, 70000);
        4: mv = 0;
        default: mv = $urandom_range(65536, 999999);
      endcase
    end else if (kind >= 84) begin
      // big frames are cut short below
      w = $urandom_range(1, MAX_WIDTH_DEF);
      h = $urandom_range(1, MAX_HEIGHT_DEF);
    end
    if ($urandom_range(0, 1)) add_gap(f);
    add_text(f, ascii ? "P2" : "P5");
    add_ws(f, 1);
    add_gap(f);
    add_num(f, w);
    add_ws(f, 1);
    add_gap(f);
    add_num(f, h);
    add_ws(f, 1);
    add_gap(f);
    add_num(f, mv);
    add_ws(f, 1);
    cells = w * h;
    npix = (cells > 48) ? $urandom_range(0, 8) : cells;
    if (npix == cells && npix != 0 && $urandom_range(0, 7) == 0)
      npix = $urandom_range(0, cells - 1);
    for (int i = 0; i < npix; i++) begin
      if (!ascii) begin
        put_byte(f, 8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 99))
          0: pix = $urandom_range(65536, 99999);
          1, 2, 3, 4, 5: pix = $urandom_range(0, 65535);
          default: pix = $urandom_range(0, (mv > 65535) ? 65535 : mv);
        endcase
        add_num(f, pix);
        if (i != npix - 1 || !closed || $urandom_range(0, 1))
          add_ws(f, $urandom_range(1, 3));
      end
    end
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 4)) put_byte(f, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) == 0)
      f[$urandom_range(0, f.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 19) == 0) begin
      cut = $urandom_range(0, f.size() - 1);
      while (f.size() > cut) f.pop_back();
    end
  endfunction

  // ---- drivers ----

  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.note_byte(it)) live_items++;
    @(negedge clk);
  endtask

  task automatic send_file(byte_q_t f, bit closed, bit marked);
    in_item_t it;
    foreach (f[i]) begin
      it.data_byte     = f[i];
      it.start_of_file = (i == 0) && marked;
      it.end_of_file   = 1'b0;
      send_item(it);
    end
    if (closed) begin
      it.data_byte     = 8'($urandom_range(0, 255));
      it.start_of_file = (f.size() == 0) && marked;
      it.end_of_file   = 1'b1;
      send_item(it);
    end
  endtask

  task automatic send_text(string s, bit closed);
    byte_q_t f;
    add_text(f, s);
    send_file(f, closed, 1'b1);
  endtask

  // hold the sender until every predicted result has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.cells_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [THR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_directed();
    byte_q_t  f;
    in_item_t it;
    f.delete();
    add_text(f, "P5 2 2 255\n");
    put_byte(f, 8'd0);
    put_byte(f, 8'd255);
    put_byte(f, 8'd128);
    put_byte(f, 8'd166);
    send_file(f, 1'b1, 1'b1);
    send_text("# lead\nP2\n# c1\n3 # c2\n1\n65535\n0 65535 30000", 1'b1);
    send_text("P6 1 1 255\n", 1'b1);
    send_text("P", 1'b1);
    it = '{data_byte: 8'hA5, start_of_file: 1'b1, end_of_file: 1'b1};
    send_item(it);
    send_text("P5x", 1'b1);
    send_text("P5 2a 1 255\n", 1'b1);
    send_text("P5 x", 1'b1);
    send_text("P5 2 1 ", 1'b1);
    send_text("P5 0 1 255\n", 1'b1);
    send_text("P5 4097 1 255\n", 1'b1);
    send_text("P5 1 4097 255\n", 1'b1);
    send_text("P5 1 1 0\n", 1'b1);
    send_text("P5 1 1 65536\n", 1'b1);
    send_text("P5 1 1 9999999\n", 1'b1);
    // largest frame, cut short after a few cells at the top row
    f.delete();
    add_text(f, "P5 4096 4096 255\n");
    put_byte(f, 8'd7);
    put_byte(f, 8'd200);
    put_byte(f, 8'd90);
    send_file(f, 1'b1, 1'b1);
    f.delete();
    add_text(f, "P5 1 4096 65535\n");
    put_byte(f, 8'd255);
    put_byte(f, 8'd0);
    send_file(f, 1'b1, 1'b1);
    send_text("P2 2 1 10\n5 x", 1'b1);
    send_text("P2 1 1 10\n70000 ", 1'b1);
    send_text("P2 1 1 10\n70000", 1'b1);
    send_text("P2 3 1 10\n200 0 # x", 1'b1);
    send_text("P2 2 1 255\n7", 1'b1);
    send_text("P5 1 1 255\n", 1'b1);
    send_text("P5 1 1 255", 1'b1);
    send_text("P5 0 1 255", 1'b1);
    f.delete();
    add_text(f, "P5 1 1 255\n");
    put_byte(f, 8'd9);
    add_text(f, "tail");
    send_file(f, 1'b1, 1'b1);
    // restarted before the frame completes
    f.delete();
    add_text(f, "P5 3 3 255\n");
    put_byte(f, 8'd1);
    send_file(f, 1'b0, 1'b1);
  endtask

  initial begin
    byte_q_t          f;
    bit               closed, marked, neg;
    logic [THR_W-1:0] occ, fre;
    int               target, seg;
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_NEGATE;
    cfg_data      = '0;
    send_idle_pct = 22;
    recv_idle_pct = 57;
    live_items    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 22; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 22; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int s = 0; s < 3; s++) begin
        seg = p * 3 + s;
        case (seg)
          0: begin neg = 1'b0; occ = OCC_THR_RST; fre = FREE_THR_RST; end
          1: begin neg = 1'b1; occ = 17'd65536;   fre = 17'd0;        end
          2: begin neg = 1'b0; occ = 17'd0;       fre = 17'd65536;    end
          3: begin neg = 1'b1; occ = 17'd32768;   fre = 17'd32768;    end
          4: begin neg = 1'b0; occ = 17'd65536;   fre = 17'd65536;    end
          5: begin neg = 1'b1; occ = 17'd0;       fre = 17'd0;        end
          default: begin
            neg = 1'($urandom_range(0, 1));
            occ = 17'($urandom_range(0, 65536));
            fre = 17'($urandom_range(0, 65536));
          end
        endcase
        wait_idle();
        write_reg(CFG_NEGATE, {16'd0, neg});
        write_reg(CFG_OCC_THR, occ);
        write_reg(CFG_FREE_THR, fre);
        target = live_items + 110;
        while (live_items < target) begin
          make_file(f, closed, marked);
          send_file(f, closed, marked);
          if ($urandom_range(0, 15) == 0) wait_idle();
        end
      end
    end
    wait_idle();
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
